@@ hw/rtl/postfix_expression_evaluator_top_assert.svh @@
// Assertion macros for the postfix evaluator checker.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PFX_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("postfix evaluator assertion failed");

// Check cons in the cycle after ante.
`define PFX_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("postfix evaluator assertion failed");

`endif

@@ hw/rtl/pfx_pkg.sv @@
// Types and constants for the postfix expression evaluator.
package pfx_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_MOD  = 8'h25;
  localparam logic [7:0] CH_POW  = 8'h5E;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
  } out_item_t;

endpackage

@@ hw/rtl/postfix_expression_evaluator_top.sv @@
// Postfix expression evaluator: operand stack, shared multiplier and serial divider.
//
//   Channel  Signals                            Dir  Contents
//   item     item_valid, item_ready, item       in   symbol (8b ASCII), last
//   result   result_valid, result_ready, result out  value (32b signed), status (3b)
//
// One item at a time; item_ready is high only while waiting for an item.
// Digit, error or ignored item: accept, then execute. + - *: execute, then pop.
// / and %: execute, the one-bit-per-cycle restoring divider, finish, then pop.
// ^: one multiplier step per squaring plus one per set exponent bit, on the
// single shared multiplier. A last item adds a result load, held while it stalls.
// Reset clears count, error and result_valid; stack words are undefined until pushed.
module postfix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  pfx_pkg::in_item_t   item,
  output logic                result_valid,
  input  logic                result_ready,
  output pfx_pkg::out_item_t  result
);
  import pfx_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_DIVFIN = 8'b0000_1000,
    S_PMUL   = 8'b0001_0000,
    S_PSQR   = 8'b0010_0000,
    S_POP    = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
  endfunction

  state_t             state;
  state_t             done_state;
  logic [7:0]         sym;
  logic               last_q;
  logic [CNT_W-1:0]   count;
  status_t            err;
  logic [DATA_W-1:0]  tos;
  logic [DATA_W-1:0]  nos;
  logic [DATA_W-1:0]  res;
  logic [DATA_W-1:0]  rd_data;
  logic [DATA_W-1:0]  mem [STACK_DEPTH];

  logic [DATA_W-1:0]  dv_rem;
  logic [DATA_W-1:0]  dv_quo;
  logic [DATA_W-1:0]  dv_den;
  logic [4:0]         dv_cnt;
  logic               dv_qneg;
  logic               dv_rneg;
  logic               dv_isrem;

  logic [DATA_W-1:0]  pw_acc;
  logic [DATA_W-1:0]  pw_base;
  logic [DATA_W-1:0]  pw_exp;

  logic [DATA_W-1:0]  mul_x;
  logic [DATA_W-1:0]  mul_y;
  logic [DATA_W-1:0]  prod;
  logic [DATA_W:0]    dv_shift;
  logic [DATA_W:0]    dv_diff;
  logic               dv_ge;
  logic               full;
  logic               is_digit;
  logic               mem_we;
  logic [CNT_W-1:0]   wr_full;
  logic [CNT_W-1:0]   rd_full;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;

  assign item_ready = (state == S_IDLE);
  assign done_state = last_q ? S_FIN : S_IDLE;

  // Shared multiplier: acc*base, base*base, or the two stack tops.
  always_comb begin
    case (state)
      S_PMUL: begin
        mul_x = pw_acc;
        mul_y = pw_base;
      end
      S_PSQR: begin
        mul_x = pw_base;
        mul_y = pw_base;
      end
      default: begin
        mul_x = nos;
        mul_y = tos;
      end
    endcase
  end
  assign prod = mul_x * mul_y;

  assign dv_shift = {dv_rem, dv_quo[DATA_W-1]};
  assign dv_diff  = dv_shift - {1'b0, dv_den};
  assign dv_ge    = !dv_diff[DATA_W];

  assign full     = (count == CNT_W'(STACK_DEPTH));
  assign is_digit = (sym >= CH_ZERO) && (sym <= CH_NINE);
  assign mem_we   = (state == S_EXEC) && (err == ST_OK) && is_digit && !full &&
                    (count >= CNT_W'(2));

  // Entries below the two top registers live in memory at their own index.
  assign wr_full = count - CNT_W'(2);
  assign rd_full = (count >= CNT_W'(3)) ? (count - CNT_W'(3)) : '0;
  assign wr_addr = wr_full[IDX_W-1:0];
  assign rd_addr = rd_full[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= nos;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      // The result load in S_FIN owns result_valid in that state.
      if (result_valid && result_ready && (state != S_FIN)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            sym    <= item.symbol;
            last_q <= item.last;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (err != ST_OK) begin
            state <= done_state;
          end else begin
            case (sym) inside
              [CH_ZERO:CH_NINE]: begin
                if (full) begin
                  err <= ST_OVER;
                end else begin
                  nos   <= tos;
                  tos   <= {24'd0, sym - CH_ZERO};
                  count <= count + CNT_W'(1);
                end
                state <= done_state;
              end
              CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD, CH_POW: begin
                if (count < CNT_W'(2)) begin
                  err   <= ST_UNDER;
                  state <= done_state;
                end else begin
                  case (sym)
                    CH_ADD: begin
                      res   <= nos + tos;
                      state <= S_POP;
                    end
                    CH_SUB: begin
                      res   <= nos - tos;
                      state <= S_POP;
                    end
                    CH_MUL: begin
                      res   <= prod;
                      state <= S_POP;
                    end
                    CH_DIV, CH_MOD: begin
                      if (tos == '0) begin
                        err   <= ST_ZERO;
                        state <= done_state;
                      end else begin
                        dv_rem   <= '0;
                        dv_quo   <= mag(nos);
                        dv_den   <= mag(tos);
                        dv_cnt   <= '0;
                        dv_qneg  <= nos[DATA_W-1] ^ tos[DATA_W-1];
                        dv_rneg  <= nos[DATA_W-1];
                        dv_isrem <= (sym == CH_MOD);
                        state    <= S_DIV;
                      end
                    end
                    default: begin
                      // Power; a negative exponent gives +-1 for bases 1 and -1, an error for base 0, else 0.
                      if (tos[DATA_W-1]) begin
                        if (nos == DATA_W'(1)) begin
                          res   <= DATA_W'(1);
                          state <= S_POP;
                        end else if (nos == '1) begin
                          res   <= tos[0] ? '1 : DATA_W'(1);
                          state <= S_POP;
                        end else if (nos == '0) begin
                          err   <= ST_ZERO;
                          state <= done_state;
                        end else begin
                          res   <= '0;
                          state <= S_POP;
                        end
                      end else if (tos == '0) begin
                        res   <= DATA_W'(1);
                        state <= S_POP;
                      end else begin
                        pw_acc  <= DATA_W'(1);
                        pw_base <= nos;
                        pw_exp  <= tos;
                        state   <= tos[0] ? S_PMUL : S_PSQR;
                      end
                    end
                  endcase
                end
              end
              default: begin
                err   <= ST_INVALID;
                state <= done_state;
              end
            endcase
          end
        end
        S_DIV: begin
          dv_rem <= dv_ge ? dv_diff[DATA_W-1:0] : dv_shift[DATA_W-1:0];
          dv_quo <= {dv_quo[DATA_W-2:0], dv_ge};
          dv_cnt <= dv_cnt + 5'd1;
          if (dv_cnt == 5'd31) begin
            state <= S_DIVFIN;
          end
        end
        S_DIVFIN: begin
          if (dv_isrem) begin
            res <= dv_rneg ? (DATA_W'(0) - dv_rem) : dv_rem;
          end else begin
            res <= dv_qneg ? (DATA_W'(0) - dv_quo) : dv_quo;
          end
          state <= S_POP;
        end
        S_PMUL: begin
          pw_acc <= prod;
          state  <= S_PSQR;
        end
        S_PSQR: begin
          pw_base <= prod;
          pw_exp  <= pw_exp >> 1;
          if (pw_exp[DATA_W-1:1] == '0) begin
            res   <= pw_acc;
            state <= S_POP;
          end else begin
            state <= pw_exp[1] ? S_PMUL : S_PSQR;
          end
        end
        S_POP: begin
          // Drop the right operand and refill the second slot from memory.
          tos   <= res;
          nos   <= rd_data;
          count <= count - CNT_W'(1);
          state <= done_state;
        end
        S_FIN: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            if (err != ST_OK) begin
              result.value  <= '0;
              result.status <= err;
            end else if (count == '0) begin
              result.value  <= '0;
              result.status <= ST_UNDER;
            end else begin
              result.value  <= tos;
              result.status <= ST_OK;
            end
            count <= '0;
            err   <= ST_OK;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/pfx_checker.sv @@
// Port-level checker for the postfix evaluator, bound to the top level.
`include "postfix_expression_evaluator_top_assert.svh"

module pfx_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input pfx_pkg::out_item_t result
);
  import pfx_pkg::*;

  `PFX_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))
  `PFX_ASSERT_NOW(a_error_value_zero, result_valid && result.status != ST_OK, result.value == '0)
  `PFX_ASSERT_NEXT(a_busy_after_item, item_valid && item_ready, !item_ready)
  `PFX_ASSERT_NEXT(a_no_instant_result, item_valid && item_ready && !result_valid, !result_valid)

endmodule

bind postfix_expression_evaluator_top pfx_checker u_pfx_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the postfix expression evaluator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pfx_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int STALL_LIMIT = 3000;
  localparam int TOTAL_ITEMS = 1850;
  localparam logic [7:0] BAD_LOW = 8'h00;
  localparam logic [7:0] BAD_HIGH = 8'hFF;
  localparam logic [7:0] BAD_SPACE = 8'h20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_item_t result;

  // Evaluator state as predicted from accepted items
  logic [31:0] calc_stack [STACK_DEPTH];
  int unsigned calc_depth = 0;
  status_t calc_error = ST_OK;
  out_item_t answer_q[$];

  logic [7:0] char_q[$];
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int sent_items = 0;
  int fail_count = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int unsigned rx_tick = 0;
  int rx_mode = 0;
  int rx_hold = 0;

  postfix_expression_evaluator_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] digit(input int d);
    return CH_ZERO + 8'(d);
  endfunction

  function automatic logic [31:0] combine(input logic [7:0] op, input logic [31:0] a,
                                          input logic [31:0] b, output status_t bad);
    logic [31:0] ma, mb, q, r, acc, base, ex;
    bad = ST_OK;
    ma = a[31] ? 32'd0 - a : a;
    mb = b[31] ? 32'd0 - b : b;
    case (op)
      CH_ADD: return a + b;
      CH_SUB: return a - b;
      CH_MUL: return a * b;
      CH_DIV, CH_MOD: begin
        if (b == 32'd0) begin
          bad = ST_ZERO;
          return 32'd0;
        end
        q = ma / mb;
        r = ma % mb;
        if (op == CH_DIV) return (a[31] != b[31]) ? 32'd0 - q : q;
        return a[31] ? 32'd0 - r : r;
      end
      default: begin
        // negative exponent: only bases of 0, 1 and -1 are special
        if (b[31]) begin
          if (a == 32'd1) return 32'd1;
          if (a == '1) return b[0] ? '1 : 32'd1;
          if (a == 32'd0) bad = ST_ZERO;
          return 32'd0;
        end
        acc = 32'd1;
        base = a;
        ex = b;
        while (ex != 32'd0) begin
          if (ex[0]) acc = acc * base;
          base = base * base;
          ex = ex >> 1;
        end
        return acc;
      end
    endcase
  endfunction

  task automatic apply_symbol(input logic [7:0] sym, input logic fin);
    logic [31:0] res;
    status_t bad;
    out_item_t ans;
    if (calc_error == ST_OK) begin
      if (sym >= CH_ZERO && sym <= CH_NINE) begin
        if (calc_depth >= STACK_DEPTH) begin
          calc_error = ST_OVER;
        end else begin
          calc_stack[calc_depth] = {24'd0, sym - CH_ZERO};
          calc_depth++;
        end
      end else if (sym != CH_ADD && sym != CH_SUB && sym != CH_MUL && sym != CH_DIV &&
                   sym != CH_MOD && sym != CH_POW) begin
        calc_error = ST_INVALID;
      end else if (calc_depth < 2) begin
        calc_error = ST_UNDER;
      end else begin
        res = combine(sym, calc_stack[calc_depth-2], calc_stack[calc_depth-1], bad);
        if (bad != ST_OK) begin
          calc_error = bad;
        end else begin
          calc_depth--;
          calc_stack[calc_depth-1] = res;
        end
      end
    end
    if (fin) begin
      if (calc_error == ST_OK && calc_depth == 0) calc_error = ST_UNDER;
      ans.value = '0;
      if (calc_error == ST_OK) ans.value = calc_stack[calc_depth-1];
      ans.status = calc_error;
      answer_q.push_back(ans);
      calc_depth = 0;
      calc_error = ST_OK;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= 100)
      $display("mismatch on %s at result %0d: got %08h, want %08h", what, results_seen,
               got, want);
  endtask

  task automatic send_item(input logic [7:0] sym, input logic fin);
    int gap;
    in_item_t pkt;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = 0;
      if (gaps_on)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 3);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pkt.symbol = sym;
    pkt.last = fin;
    item_valid <= 1'b1;
    item <= pkt;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent_items++;
    apply_symbol(sym, fin);
  endtask

  task automatic put(input logic [7:0] c);
    char_q.push_back(c);
  endtask

  // Send the queued characters as one expression, last mark on the final one
  task automatic send_queue();
    for (int i = 0; i < char_q.size(); i++) send_item(char_q[i], i == char_q.size() - 1);
    char_q.delete();
  endtask

  task automatic put_negative(input int d);
    put(digit(0)); put(digit(d)); put(CH_SUB);
  endtask

  // 2 ^ 31 wraps to the most negative number
  task automatic put_int_min();
    put(digit(2)); put(digit(4)); put(digit(8)); put(CH_MUL); put(digit(1)); put(CH_SUB);
    put(CH_POW);
  endtask

  task automatic put_random_op();
    logic [7:0] ops [6];
    ops = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD, CH_POW};
    put(ops[$urandom_range(0, 5)]);
  endtask

  task automatic put_operand();
    case ($urandom_range(0, 9))
      5: put_negative(1);
      6: put_negative($urandom_range(0, 9));
      7: put_int_min();
      8: begin
        put(digit($urandom_range(5, 9))); put(digit($urandom_range(5, 9))); put(CH_MUL);
        put(digit($urandom_range(5, 9))); put(CH_MUL);
        put(digit($urandom_range(5, 9))); put(CH_MUL);
      end
      9: begin
        put(digit($urandom_range(0, 9))); put(digit($urandom_range(0, 9))); put(CH_POW);
      end
      default: put(digit($urandom_range(0, 9)));
    endcase
  endtask

  task automatic build_expression();
    int mode, depth;
    mode = $urandom_range(0, 19);
    depth = 0;
    if (mode == 19) begin
      // run the stack up to and past its depth
      repeat ($urandom_range(30, 34)) put(digit($urandom_range(0, 9)));
      repeat ($urandom_range(0, 2)) put_random_op();
    end else begin
      repeat ($urandom_range(1, 7)) begin
        put_operand();
        depth++;
        while (depth >= 2 && $urandom_range(0, 2) != 0) begin
          put_random_op();
          depth--;
        end
      end
      while (depth > 1 && $urandom_range(0, 4) != 0) begin
        put_random_op();
        depth--;
      end
    end
    if (mode <= 2) begin
      char_q[$urandom_range(0, char_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (mode == 3) begin
      char_q.push_front(CH_POW);
    end else if (mode == 4) begin
      char_q.delete(char_q.size() - 1);
      if (char_q.size() == 0) put(CH_DIV);
    end
  endtask

  task automatic test_digits_and_arithmetic();
    put(digit(0)); send_queue();
    put(digit(9)); send_queue();
    put(digit(9)); put(digit(8)); put(CH_ADD); send_queue();
    put(digit(3)); put(digit(8)); put(CH_SUB); send_queue();
    put(digit(9)); put(digit(7)); put(CH_MUL); send_queue();
    put(digit(9)); put(digit(4)); put(CH_DIV); send_queue();
    put_negative(7); put(digit(2)); put(CH_DIV); send_queue();
    put_negative(7); put(digit(2)); put(CH_MOD); send_queue();
    put(digit(7)); put_negative(2); put(CH_MOD); send_queue();
    put(digit(2)); put(digit(9)); put(CH_POW); send_queue();
    // extra entries: only the top comes out
    put(digit(1)); put(digit(2)); put(digit(3)); send_queue();
  endtask

  task automatic test_error_cases();
    put(CH_ADD); send_queue();
    put(digit(5)); put(CH_MUL); send_queue();
    put(digit(9)); put(digit(0)); put(CH_DIV); send_queue();
    put(digit(5)); put(digit(0)); put(CH_MOD); send_queue();
    put(BAD_HIGH); send_queue();
    // everything after the first error is dropped
    put(digit(3)); put(BAD_LOW); put(digit(4)); put(CH_ADD); send_queue();
    put(digit(2)); put(BAD_SPACE); put(CH_DIV); send_queue();
    put(digit(4)); send_queue();
  endtask

  task automatic test_wraparound();
    put_int_min(); put_negative(1); put(CH_DIV); send_queue();
    put_int_min(); put_negative(1); put(CH_MOD); send_queue();
    put_int_min(); put(digit(1)); put(CH_SUB); send_queue();
    put(digit(9)); put(digit(9)); put(CH_POW); put(digit(9)); put(CH_MUL); send_queue();
  endtask

  task automatic test_power_cases();
    put(digit(0)); put(digit(0)); put(CH_POW); send_queue();
    put(digit(2)); put_negative(1); put(CH_POW); send_queue();
    put(digit(0)); put_negative(1); put(CH_POW); send_queue();
    put(digit(1)); put_negative(3); put(CH_POW); send_queue();
    put_negative(1); put_negative(1); put(CH_POW); send_queue();
    put_negative(1); put_negative(2); put(CH_POW); send_queue();
    put(digit(2)); put_int_min(); put(CH_POW); send_queue();
    // largest positive exponent: every bit below the sign bit set
    put(digit(3)); put_int_min(); put(digit(1)); put(CH_SUB); put(CH_POW); send_queue();
  endtask

  task automatic test_stack_limits();
    repeat (STACK_DEPTH) put(digit(9));
    send_queue();
    repeat (STACK_DEPTH + 1) put(digit(8));
    send_queue();
    repeat (STACK_DEPTH) put(digit(7));
    put(CH_ADD); put(digit(1)); send_queue();
  endtask

  // Fill up the item budget with random expressions
  task automatic test_random_expressions();
    while (sent_items < TOTAL_ITEMS) begin
      if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
      build_expression();
      send_queue();
    end
  endtask

  // Result sink: stalls in changing patterns
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 300 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= rx_tick[0];
      2: result_ready <= ($urandom_range(0, 9) < 6);
      default: begin
        if (rx_hold != 0) begin
          result_ready <= 1'b0;
          rx_hold <= rx_hold - 1;
        end else begin
          result_ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) rx_hold <= $urandom_range(1, 24);
        end
      end
    endcase
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected result", result.value, '0);
      end else begin
        want = answer_q.pop_front();
        if (result.value !== want.value) report_mismatch("value", result.value, want.value);
        if (result.status !== want.status)
          report_mismatch("status", {29'd0, result.status}, {29'd0, want.status});
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_digits_and_arithmetic();
    test_error_cases();
    test_wraparound();
    test_power_cases();
    test_stack_limits();
    test_random_expressions();
    item_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
